@@ hw/rtl/ssbs_pkg.sv @@
`default_nettype none

package ssbs_pkg;

  // field widths fixed by the interface
  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int KEY_W   = SCORE_W + 1;
  localparam int BOX_W   = 4 * COORD_W;
  localparam int THR_W   = 17;
  localparam int LIMIT_W = 7;
  localparam int KEPT_W  = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'b1;

  localparam logic [THR_W-1:0]   THR_RESET   = 17'd19661;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ZERO,
    ST_SINIT,
    ST_SORT,
    ST_COPY,
    ST_OI_RD,
    ST_OI_A,
    ST_OI_B,
    ST_IJ_RD,
    ST_IJ_A,
    ST_IJ_B,
    ST_M1,
    ST_UN,
    ST_M2,
    ST_M3,
    ST_CMP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic zero_out;
    logic sinit;
    logic sort_pass;
    logic copy;
    logic ginit;
    logic oi_rd;
    logic oi_a;
    logic oi_b;
    logic ij_rd;
    logic ij_b;
    logic m1;
    logic un;
    logic m2;
    logic m3;
    logic cmp;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic sort_done;
    logic copy_done;
    logic i_end;
    logic mark_i;
    logic kc_last;
    logic j_end;
    logic mark_j;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/ssbs_ctrl.sv @@
`default_nettype none

module ssbs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          in_last_box,
  input  wire ssbs_pkg::sts_t sts,
  output ssbs_pkg::cmd_t     cmd,
  output logic               busy
);

  ssbs_pkg::state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ssbs_pkg::ST_IDLE);

  // sequence load, sort, copy and greedy walk, or the zero-limit result
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      ssbs_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last_box) begin
            state_nxt = sts.limit_zero ? ssbs_pkg::ST_ZERO : ssbs_pkg::ST_SINIT;
          end
        end
      end
      ssbs_pkg::ST_ZERO: begin
        cmd.zero_out = 1'b1;
        state_nxt = ssbs_pkg::ST_IDLE;
      end
      ssbs_pkg::ST_SINIT: begin
        cmd.sinit = 1'b1;
        state_nxt = ssbs_pkg::ST_SORT;
      end
      ssbs_pkg::ST_SORT: begin
        cmd.sort_pass = 1'b1;
        if (sts.sort_done) state_nxt = ssbs_pkg::ST_COPY;
      end
      ssbs_pkg::ST_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_done) begin
          cmd.ginit = 1'b1;
          state_nxt = ssbs_pkg::ST_OI_RD;
        end
      end
      ssbs_pkg::ST_OI_RD: begin
        cmd.oi_rd = 1'b1;
        if (sts.i_end) state_nxt = ssbs_pkg::ST_FINISH;
        else if (!sts.mark_i) state_nxt = ssbs_pkg::ST_OI_A;
      end
      ssbs_pkg::ST_OI_A: begin
        cmd.oi_a = 1'b1;
        state_nxt = ssbs_pkg::ST_OI_B;
      end
      ssbs_pkg::ST_OI_B: begin
        cmd.oi_b = 1'b1;
        state_nxt = sts.kc_last ? ssbs_pkg::ST_FINISH : ssbs_pkg::ST_IJ_RD;
      end
      ssbs_pkg::ST_IJ_RD: begin
        cmd.ij_rd = 1'b1;
        if (sts.j_end) state_nxt = ssbs_pkg::ST_OI_RD;
        else if (!sts.mark_j) state_nxt = ssbs_pkg::ST_IJ_A;
      end
      ssbs_pkg::ST_IJ_A: state_nxt = ssbs_pkg::ST_IJ_B;
      ssbs_pkg::ST_IJ_B: begin
        cmd.ij_b = 1'b1;
        state_nxt = ssbs_pkg::ST_M1;
      end
      ssbs_pkg::ST_M1: begin
        cmd.m1 = 1'b1;
        state_nxt = ssbs_pkg::ST_UN;
      end
      ssbs_pkg::ST_UN: begin
        cmd.un = 1'b1;
        state_nxt = ssbs_pkg::ST_M2;
      end
      ssbs_pkg::ST_M2: begin
        cmd.m2 = 1'b1;
        state_nxt = ssbs_pkg::ST_M3;
      end
      ssbs_pkg::ST_M3: begin
        cmd.m3 = 1'b1;
        state_nxt = ssbs_pkg::ST_CMP;
      end
      ssbs_pkg::ST_CMP: begin
        cmd.cmp = 1'b1;
        state_nxt = ssbs_pkg::ST_IJ_RD;
      end
      ssbs_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = ssbs_pkg::ST_IDLE;
      end
      default: state_nxt = ssbs_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ssbs_dp.sv @@
`default_nettype none

module ssbs_dp #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ssbs_pkg::cmd_t                   cmd,
  output ssbs_pkg::sts_t                        sts,
  input  wire logic                             cfg_we,
  input  wire logic [ssbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ssbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [ssbs_pkg::COORD_W-1:0]     in_left_edge,
  input  wire logic [ssbs_pkg::COORD_W-1:0]     in_top_edge,
  input  wire logic [ssbs_pkg::COORD_W-1:0]     in_right_edge,
  input  wire logic [ssbs_pkg::COORD_W-1:0]     in_bottom_edge,
  input  wire logic [ssbs_pkg::SCORE_W-1:0]     in_confidence,
  output logic                                  out_strobe,
  output logic [ssbs_pkg::KEPT_W-1:0]           out_kept_index,
  output logic                                  out_last_result,
  output logic                                  out_none_kept,
  output logic                                  out_overflowed
);

  localparam int IW    = $clog2(MAX_BOXES);
  localparam int CW    = $clog2(MAX_BOXES + 1);
  localparam int LW    = ($clog2(MAX_BOXES) < 3) ? 3 : $clog2(MAX_BOXES);
  localparam int LANES = 1 << LW;
  localparam int KW    = $clog2(LW + 1);
  localparam int KEY_W = ssbs_pkg::KEY_W;
  localparam int CD_W  = ssbs_pkg::COORD_W;
  localparam int THR_W = ssbs_pkg::THR_W;
  localparam int LIM_W = ssbs_pkg::LIMIT_W;

  // configuration
  logic [THR_W-1:0] thr_r;
  logic [LIM_W-1:0] lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ssbs_pkg::THR_RESET;
      lim_r <= ssbs_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == ssbs_pkg::REG_THRESH) thr_r <= cfg_wdata[THR_W-1:0];
      if (cfg_index == ssbs_pkg::REG_LIMIT)  lim_r <= cfg_wdata[LIM_W-1:0];
    end
  end

  // set bookkeeping
  logic [CW-1:0]        cnt_r;
  logic                 ovf_r;
  logic [MAX_BOXES-1:0] mark_r;
  logic [CW-1:0]        i_r, j_r;
  logic [LIM_W-1:0]     kc_r;
  logic [KW-1:0]        kl_r, jl_r, pl;
  logic                 pend_v_r;
  logic [IW-1:0]        pend_r, aidx_r;

  // sort lanes
  logic [KEY_W-1:0] key_r [LANES];
  logic [IW-1:0]    ord_r [LANES];
  logic [KEY_W-1:0] sort_key [LANES];
  logic [IW-1:0]    sort_ord [LANES];
  logic [LW-1:0]    pidx [LANES];
  logic [LW:0]      lane_id [LANES];
  logic [LW-1:0]    jmask;

  // memories
  logic [ssbs_pkg::BOX_W-1:0] box_mem [MAX_BOXES];
  logic [IW-1:0]              ord_mem [MAX_BOXES];
  logic [ssbs_pkg::BOX_W-1:0] box_q, a_r;
  logic [IW-1:0]              ord_q;
  logic [IW-1:0]              ord_addr;

  // overlap pipeline
  logic [CD_W-1:0]          iw_r, ih_r;
  logic signed [CD_W:0]     dxa_r, dya_r, dxb_r, dyb_r;
  logic [2*CD_W-1:0]        inter_r;
  logic signed [2*CD_W+1:0] aa_r, ab_r;
  logic signed [2*CD_W+3:0] uni_r;
  logic                     nonpos_r;
  logic [2*THR_W-1:0]       plo_r, phi_r;

  logic signed [CD_W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  logic signed [CD_W-1:0] ix1, iy1, ix2, iy2;
  logic signed [CD_W:0]   iwd, ihd;
  logic [3*THR_W-1:0]     prod, lhs;
  logic                   hit;

  // status toward the controller
  always_comb begin
    pl = KW'(3);
    for (int b = 3; b < LW; b++) begin
      if (cnt_r > CW'(1 << b)) pl = KW'(b + 1);
    end
    sts.limit_zero = (lim_r == '0);
    sts.sort_done  = (jl_r == '0) && (kl_r == pl);
    sts.copy_done  = (i_r == cnt_r);
    sts.i_end      = (i_r == cnt_r);
    sts.mark_i     = mark_r[i_r[IW-1:0]];
    sts.kc_last    = ({1'b0, kc_r} + (LIM_W+1)'(1)) == {1'b0, lim_r};
    sts.j_end      = (j_r == cnt_r);
    sts.mark_j     = mark_r[j_r[IW-1:0]];
  end

  // one bitonic pass across all lanes
  always_comb begin
    jmask = LW'(1) << jl_r;
    for (int i = 0; i < LANES; i++) begin
      logic up, sw;
      logic [KEY_W-1:0] pk;
      lane_id[i] = (LW+1)'(i);
      pidx[i] = lane_id[i][LW-1:0] ^ jmask;
      up = !lane_id[i][kl_r];
      pk = key_r[pidx[i]];
      if ((lane_id[i][LW-1:0] & jmask) == '0) begin
        sw = up ? (key_r[i] < pk) : (key_r[i] > pk);
      end else begin
        sw = up ? (pk < key_r[i]) : (pk > key_r[i]);
      end
      sort_key[i] = sw ? pk : key_r[i];
      sort_ord[i] = sw ? ord_r[pidx[i]] : ord_r[i];
    end
  end

  // lane registers: load, pad, sort, shift out
  always_ff @(posedge clk) begin
    if (cmd.load && (cnt_r != CW'(MAX_BOXES))) begin
      key_r[cnt_r[LW-1:0]] <= KEY_W'(in_confidence) + KEY_W'(1);
    end
    if (cmd.sinit) begin
      for (int i = 0; i < LANES; i++) begin
        if (i < int'(cnt_r)) begin
          ord_r[i] <= IW'(i);
        end else begin
          key_r[i] <= '0;
          ord_r[i] <= '0;
        end
      end
    end
    if (cmd.sort_pass) begin
      for (int i = 0; i < LANES; i++) begin
        key_r[i] <= sort_key[i];
        ord_r[i] <= sort_ord[i];
      end
    end
    if (cmd.copy) begin
      for (int i = 0; i < LANES - 1; i++) ord_r[i] <= ord_r[i+1];
      ord_r[LANES-1] <= '0;
    end
  end

  // pass counters
  always_ff @(posedge clk) begin
    if (cmd.sinit) begin
      kl_r <= KW'(1);
      jl_r <= '0;
    end else if (cmd.sort_pass) begin
      if (jl_r == '0) begin
        kl_r <= kl_r + KW'(1);
        jl_r <= kl_r;
      end else begin
        jl_r <= jl_r - KW'(1);
      end
    end
  end

  // memory ports
  assign ord_addr = cmd.oi_rd ? i_r[IW-1:0] : j_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && (cnt_r != CW'(MAX_BOXES))) begin
      box_mem[cnt_r[IW-1:0]] <= {in_bottom_edge, in_right_edge, in_top_edge, in_left_edge};
    end
    box_q <= box_mem[ord_q];
  end

  always_ff @(posedge clk) begin
    if (cmd.copy && !sts.copy_done) ord_mem[i_r[IW-1:0]] <= ord_r[0];
    ord_q <= ord_mem[ord_addr];
  end

  // control counters and marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      mark_r   <= '0;
      i_r      <= '0;
      j_r      <= '0;
      kc_r     <= '0;
      pend_v_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (cnt_r != CW'(MAX_BOXES)) cnt_r <= cnt_r + CW'(1);
        else ovf_r <= 1'b1;
      end
      if (cmd.sinit) i_r <= '0;
      if (cmd.copy && !sts.copy_done) i_r <= i_r + CW'(1);
      if (cmd.ginit) begin
        i_r      <= '0;
        kc_r     <= '0;
        pend_v_r <= 1'b0;
      end
      if (cmd.oi_rd && !sts.i_end && sts.mark_i) i_r <= i_r + CW'(1);
      if (cmd.oi_b) begin
        j_r      <= i_r + CW'(1);
        kc_r     <= kc_r + LIM_W'(1);
        pend_v_r <= 1'b1;
      end
      if (cmd.ij_rd) begin
        if (sts.j_end) i_r <= i_r + CW'(1);
        else if (sts.mark_j) j_r <= j_r + CW'(1);
      end
      if (cmd.cmp) begin
        if (hit) mark_r[j_r[IW-1:0]] <= 1'b1;
        j_r <= j_r + CW'(1);
      end
      if (cmd.finish || cmd.zero_out) begin
        cnt_r    <= '0;
        ovf_r    <= 1'b0;
        mark_r   <= '0;
        pend_v_r <= 1'b0;
      end
    end
  end

  // latch the kept box and its index
  always_ff @(posedge clk) begin
    if (cmd.oi_a) aidx_r <= ord_q;
    if (cmd.oi_b) begin
      a_r    <= box_q;
      pend_r <= aidx_r;
    end
  end

  // overlap: edges and extents
  always_comb begin
    ax1 = $signed(a_r[CD_W-1:0]);
    ay1 = $signed(a_r[2*CD_W-1:CD_W]);
    ax2 = $signed(a_r[3*CD_W-1:2*CD_W]);
    ay2 = $signed(a_r[4*CD_W-1:3*CD_W]);
    bx1 = $signed(box_q[CD_W-1:0]);
    by1 = $signed(box_q[2*CD_W-1:CD_W]);
    bx2 = $signed(box_q[3*CD_W-1:2*CD_W]);
    by2 = $signed(box_q[4*CD_W-1:3*CD_W]);
    ix1 = (ax1 > bx1) ? ax1 : bx1;
    iy1 = (ay1 > by1) ? ay1 : by1;
    ix2 = (ax2 < bx2) ? ax2 : bx2;
    iy2 = (ay2 < by2) ? ay2 : by2;
    iwd = (CD_W+1)'(ix2) - (CD_W+1)'(ix1);
    ihd = (CD_W+1)'(iy2) - (CD_W+1)'(iy1);
    prod = ((3*THR_W)'(phi_r) << THR_W) + (3*THR_W)'(plo_r);
    lhs  = (3*THR_W)'(inter_r) << 16;
    hit  = nonpos_r ? (thr_r == '0) : (lhs >= prod);
  end

  // overlap: registered extents, products, union and threshold products
  always_ff @(posedge clk) begin
    if (cmd.ij_b) begin
      iw_r  <= iwd[CD_W] ? '0 : iwd[CD_W-1:0];
      ih_r  <= ihd[CD_W] ? '0 : ihd[CD_W-1:0];
      dxa_r <= (CD_W+1)'(ax2) - (CD_W+1)'(ax1);
      dya_r <= (CD_W+1)'(ay2) - (CD_W+1)'(ay1);
      dxb_r <= (CD_W+1)'(bx2) - (CD_W+1)'(bx1);
      dyb_r <= (CD_W+1)'(by2) - (CD_W+1)'(by1);
    end
    if (cmd.m1) begin
      inter_r <= iw_r * ih_r;
      aa_r    <= dxa_r * dya_r;
      ab_r    <= dxb_r * dyb_r;
    end
    if (cmd.un) begin
      uni_r <= (2*CD_W+4)'(aa_r) + (2*CD_W+4)'(ab_r)
             - $signed({4'b0000, inter_r});
    end
    if (cmd.m2) begin
      nonpos_r <= (uni_r <= 0);
      plo_r    <= thr_r * uni_r[THR_W-1:0];
    end
    if (cmd.m3) begin
      phi_r <= thr_r * uni_r[2*THR_W-1:THR_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.zero_out || cmd.finish || (cmd.oi_b && pend_v_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.zero_out || cmd.finish || cmd.oi_b) begin
      out_kept_index  <= cmd.zero_out ? '0 : ssbs_pkg::KEPT_W'(pend_r);
      out_last_result <= cmd.zero_out || cmd.finish;
      out_none_kept   <= cmd.zero_out;
      out_overflowed  <= ovf_r;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/score_sort_box_suppression.sv @@
`default_nettype none

// Greedy non-maximum suppression. Boxes load one per cycle (start high while
// busy is low); a box with in_last_box closes the set and busy rises. After the
// setup state the set is ranked by descending confidence on a bitonic lane
// network, one compare-exchange pass per cycle (p(p+1)/2 passes, p = log2 of
// the set size padded to a power of two, at least 3), then the sorted order is
// shifted into an index memory. The greedy walk reads each kept box through
// OI_RD, OI_A and OI_B, stops once the keep limit is reached, and skips boxes
// already suppressed in either loop; each overlap test steps through IJ_RD,
// IJ_A, IJ_B, M1, UN, M2, M3 and CMP, sharing the box memory's single read port.
// Kept arrival indices come out on out_strobe, one cycle each, with no way to
// stall them; out_last_result marks the final one, and the block is idle again
// in that cycle. A keep limit of zero yields one result with out_none_kept set.
// Boxes beyond MAX_BOXES are dropped and flagged on out_overflowed.
module score_sort_box_suppression #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [ssbs_pkg::COORD_W-1:0]     in_left_edge,
  input  wire logic [ssbs_pkg::COORD_W-1:0]     in_top_edge,
  input  wire logic [ssbs_pkg::COORD_W-1:0]     in_right_edge,
  input  wire logic [ssbs_pkg::COORD_W-1:0]     in_bottom_edge,
  input  wire logic [ssbs_pkg::SCORE_W-1:0]     in_confidence,
  input  wire logic                             in_last_box,
  output logic                                  out_strobe,
  output logic [ssbs_pkg::KEPT_W-1:0]           out_kept_index,
  output logic                                  out_last_result,
  output logic                                  out_none_kept,
  output logic                                  out_overflowed,
  input  wire logic                             cfg_we,
  input  wire logic [ssbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ssbs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ssbs_pkg::cmd_t cmd;
  ssbs_pkg::sts_t sts;

  ssbs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_last_box (in_last_box),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  ssbs_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_left_edge    (in_left_edge),
    .in_top_edge     (in_top_edge),
    .in_right_edge   (in_right_edge),
    .in_bottom_edge  (in_bottom_edge),
    .in_confidence   (in_confidence),
    .out_strobe      (out_strobe),
    .out_kept_index  (out_kept_index),
    .out_last_result (out_last_result),
    .out_none_kept   (out_none_kept),
    .out_overflowed  (out_overflowed)
  );

`ifndef NO_ASSERTIONS
  // final result leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_result |-> !busy)
    else $error("final result while busy");

  // earlier results only come mid-walk
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_result |-> busy)
    else $error("non-final result while idle");

  // zero keep limit gives a single closing result
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_none_kept |-> out_last_result)
    else $error("none_kept without last_result");

  // a box that does not close the set produces nothing
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last_box |=> !busy && !out_strobe)
    else $error("activity after an open-set load");
`endif

endmodule

`default_nettype wire

@@ verif/nms_checker.sv @@
`timescale 1ns / 100ps

module nms_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic                            busy,
  input  wire logic [ssbs_pkg::COORD_W-1:0]    in_left_edge,
  input  wire logic [ssbs_pkg::COORD_W-1:0]    in_top_edge,
  input  wire logic [ssbs_pkg::COORD_W-1:0]    in_right_edge,
  input  wire logic [ssbs_pkg::COORD_W-1:0]    in_bottom_edge,
  input  wire logic [ssbs_pkg::SCORE_W-1:0]    in_confidence,
  input  wire logic                            in_last_box,
  input  wire logic                            out_strobe,
  input  wire logic [ssbs_pkg::KEPT_W-1:0]     out_kept_index,
  input  wire logic                            out_last_result,
  input  wire logic                            out_none_kept,
  input  wire logic                            out_overflowed,
  input  wire logic                            cfg_we,
  input  wire logic [ssbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                   fail_count,
  output int                                   kept_pending
);

  localparam int CAPACITY = 64;

  typedef struct packed {
    logic [ssbs_pkg::KEPT_W-1:0] index;
    logic                        last;
    logic                        none;
    logic                        ovf;
  } kept_t;

  kept_t kept_q[$];

  logic signed [ssbs_pkg::COORD_W-1:0] x1_mem[CAPACITY];
  logic signed [ssbs_pkg::COORD_W-1:0] y1_mem[CAPACITY];
  logic signed [ssbs_pkg::COORD_W-1:0] x2_mem[CAPACITY];
  logic signed [ssbs_pkg::COORD_W-1:0] y2_mem[CAPACITY];
  logic [ssbs_pkg::SCORE_W-1:0]        conf_mem[CAPACITY];
  int                                  box_cnt;
  bit                                  ovf_flag;
  logic [ssbs_pkg::THR_W-1:0]          overlap_min;
  logic [ssbs_pkg::LIMIT_W-1:0]        keep_max;

  assign kept_pending = kept_q.size();

  // IoU at or above threshold, tested without division
  function automatic bit iou_hit(int a, int b);
    longint ix1, iy1, ix2, iy2, iw, ih, inter, uni;
    ix1 = (x1_mem[a] > x1_mem[b]) ? x1_mem[a] : x1_mem[b];
    iy1 = (y1_mem[a] > y1_mem[b]) ? y1_mem[a] : y1_mem[b];
    ix2 = (x2_mem[a] < x2_mem[b]) ? x2_mem[a] : x2_mem[b];
    iy2 = (y2_mem[a] < y2_mem[b]) ? y2_mem[a] : y2_mem[b];
    iw = ix2 - ix1;
    ih = iy2 - iy1;
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    inter = iw * ih;
    uni = (longint'(x2_mem[a]) - x1_mem[a]) * (longint'(y2_mem[a]) - y1_mem[a])
        + (longint'(x2_mem[b]) - x1_mem[b]) * (longint'(y2_mem[b]) - y1_mem[b])
        - inter;
    if (uni <= 0) return overlap_min == 0;
    return inter * 65536 >= longint'(overlap_min) * uni;
  endfunction

  // rank the set on the padded bitonic network, then run greedy suppression
  function automatic void predict_kept();
    int     key[CAPACITY];
    int     ord[CAPACITY];
    bit     sup[CAPACITY];
    int     p, k, j, i, l, t, emitted;
    bit     up, sw;
    kept_t  r;
    p = 8;
    while (p < box_cnt && p < CAPACITY) p = p << 1;
    for (i = 0; i < p; i++) begin
      key[i] = (i < box_cnt) ? conf_mem[i] + 1 : 0;
      ord[i] = (i < box_cnt) ? i : 0;
      sup[i] = 1'b0;
    end
    for (k = 2; k <= p; k = k << 1) begin
      for (j = k >> 1; j > 0; j = j >> 1) begin
        for (i = 0; i < p; i++) begin
          l = i ^ j;
          if (l > i) begin
            up = (i & k) == 0;
            sw = up ? (key[i] < key[l]) : (key[i] > key[l]);
            if (sw) begin
              t = key[i]; key[i] = key[l]; key[l] = t;
              t = ord[i]; ord[i] = ord[l]; ord[l] = t;
            end
          end
        end
      end
    end
    if (keep_max == 0) begin
      r = '{index: '0, last: 1'b1, none: 1'b1, ovf: ovf_flag};
      kept_q.push_back(r);
      return;
    end
    emitted = 0;
    for (i = 0; i < box_cnt; i++) begin
      if (!sup[i]) begin
        if (emitted < keep_max) begin
          r = '{index: ord[i][ssbs_pkg::KEPT_W-1:0], last: 1'b0, none: 1'b0,
                ovf: ovf_flag};
          kept_q.push_back(r);
          emitted++;
        end
        for (j = i + 1; j < box_cnt; j++)
          if (!sup[j] && iou_hit(ord[i], ord[j])) sup[j] = 1'b1;
      end
    end
    kept_q[kept_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    kept_t want;
    if (!rst_n) begin
      box_cnt     = 0;
      ovf_flag    = 1'b0;
      overlap_min = ssbs_pkg::THR_RESET;
      keep_max    = ssbs_pkg::LIMIT_RESET;
      fail_count <= 0;
      kept_q.delete();
    end else begin
      // compare each result transaction with the oldest expectation
      if (out_strobe) begin
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected result index=%0d last=%0b none=%0b ovf=%0b",
                   $time, out_kept_index, out_last_result, out_none_kept, out_overflowed);
          fail_count <= fail_count + 1;
        end else begin
          want = kept_q.pop_front();
          if ((!want.none && out_kept_index !== want.index) ||
              out_last_result !== want.last || out_none_kept !== want.none ||
              out_overflowed !== want.ovf) begin
            $display("%0t: result mismatch expected index=%0d last=%0b none=%0b ovf=%0b",
                     $time, want.index, want.last, want.none, want.ovf);
            $display("%0t:                 actual   index=%0d last=%0b none=%0b ovf=%0b",
                     $time, out_kept_index, out_last_result, out_none_kept,
                     out_overflowed);
            fail_count <= fail_count + 1;
          end
        end
      end
      // track register writes
      if (cfg_we) begin
        if (cfg_index == ssbs_pkg::REG_THRESH) overlap_min = cfg_wdata[ssbs_pkg::THR_W-1:0];
        else if (cfg_index == ssbs_pkg::REG_LIMIT) keep_max = cfg_wdata[ssbs_pkg::LIMIT_W-1:0];
      end
      // store accepted boxes, close the set on the last one
      if (start && !busy) begin
        if (box_cnt < CAPACITY) begin
          x1_mem[box_cnt]   = in_left_edge;
          y1_mem[box_cnt]   = in_top_edge;
          x2_mem[box_cnt]   = in_right_edge;
          y2_mem[box_cnt]   = in_bottom_edge;
          conf_mem[box_cnt] = in_confidence;
          box_cnt           = box_cnt + 1;
        end else begin
          ovf_flag = 1'b1;
        end
        if (in_last_box) begin
          predict_kept();
          box_cnt  = 0;
          ovf_flag = 1'b0;
        end
      end
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic [ssbs_pkg::COORD_W-1:0]    in_left_edge;
  logic [ssbs_pkg::COORD_W-1:0]    in_top_edge;
  logic [ssbs_pkg::COORD_W-1:0]    in_right_edge;
  logic [ssbs_pkg::COORD_W-1:0]    in_bottom_edge;
  logic [ssbs_pkg::SCORE_W-1:0]    in_confidence;
  logic                            in_last_box;
  logic                            out_strobe;
  logic [ssbs_pkg::KEPT_W-1:0]     out_kept_index;
  logic                            out_last_result;
  logic                            out_none_kept;
  logic                            out_overflowed;
  logic                            cfg_we;
  logic [ssbs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ssbs_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                              fail_count;
  int                              kept_pending;
  int                              idle_pct;
  int                              box_total;

  score_sort_box_suppression #(.MAX_BOXES(64)) DUT (.*);

  nms_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

  // drive one box transaction and hold it until accepted
  task automatic send_box(int x1, int y1, int x2, int y2, int conf, bit last);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start          = 1'b1;
    in_left_edge   = x1[15:0];
    in_top_edge    = y1[15:0];
    in_right_edge  = x2[15:0];
    in_bottom_edge = y2[15:0];
    in_confidence  = conf[15:0];
    in_last_box    = last;
    while (busy) @(negedge clk);
    @(negedge clk);
    box_total++;
  endtask

  // drop start and let all kept results drain
  task automatic drain();
    start = 1'b0;
    while (kept_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [ssbs_pkg::CFG_IDX_W-1:0] idx, int data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data[ssbs_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // random set: mostly clustered boxes so overlaps vary, some wild ones
  task automatic send_set(int count);
    int cx, cy, x1, y1, w, h, conf;
    cx = $urandom_range(0, 400) - 200;
    cy = $urandom_range(0, 400) - 200;
    for (int b = 0; b < count; b++) begin
      if ($urandom_range(9) == 0) begin
        x1 = $urandom; y1 = $urandom; w = $urandom; h = $urandom;
        send_box(x1, y1, w, h, $urandom, b == count - 1);
      end else begin
        x1 = cx + $urandom_range(0, 30);
        y1 = cy + $urandom_range(0, 30);
        w  = $urandom_range(0, 60) - 5;
        h  = $urandom_range(0, 60) - 5;
        conf = ($urandom_range(3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
        send_box(x1, y1, x1 + w, y1 + h, conf, b == count - 1);
      end
    end
  endtask

  initial begin
    int thr_set[6];
    int lim_set[6];
    int pct_set[3];
    int sz;
    thr_set = '{19661, 0, 65536, 131071, 32768, 0};
    lim_set = '{64, 1, 127, 0, 3, 64};
    pct_set = '{0, 65, 23};
    rst_n = 1'b0;
    start = 1'b0;
    in_left_edge = '0; in_top_edge = '0; in_right_edge = '0; in_bottom_edge = '0;
    in_confidence = '0; in_last_box = 1'b0;
    cfg_we = 1'b0; cfg_index = ssbs_pkg::REG_THRESH; cfg_wdata = '0;
    idle_pct = 0;
    box_total = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, ties, inverted and zero-area boxes at reset settings
    send_box(-32768, -32768, 32767, 32767, 65535, 1'b0);
    send_box(-32768, -32768, 32767, 32767, 65535, 1'b0);
    send_box(10, 10, 0, 0, 0, 1'b0);
    send_box(5, 5, 5, 5, 100, 1'b0);
    send_box(0, 0, 20, 20, 100, 1'b0);
    send_box(2, 2, 22, 22, 100, 1'b1);
    send_box(7, 7, 7, 7, 65535, 1'b1);
    drain();
    // zero union suppresses only at a zero threshold
    write_reg(ssbs_pkg::REG_THRESH, 0);
    send_box(3, 3, 3, 3, 500, 1'b0);
    send_box(9, 9, 9, 9, 400, 1'b0);
    send_box(100, 100, 0, 0, 300, 1'b1);
    drain();
    write_reg(ssbs_pkg::REG_LIMIT, 0);
    send_box(1, 2, 3, 4, 9, 1'b1);
    drain();
    write_reg(ssbs_pkg::REG_LIMIT, 1);
    write_reg(ssbs_pkg::REG_THRESH, 65536);
    send_box(0, 0, 10, 10, 1, 1'b0);
    send_box(0, 0, 10, 10, 2, 1'b1);
    drain();

    // random phases across register settings and sender gaps
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(ssbs_pkg::REG_THRESH,
                (ph == 10) ? $urandom_range(0, 131071) : thr_set[ph % 6]);
      write_reg(ssbs_pkg::REG_LIMIT, (ph == 11) ? $urandom_range(0, 127) : lim_set[ph % 6]);
      idle_pct = pct_set[ph % 3];
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(19))
          0:       sz = $urandom_range(64, 70);
          1, 2:    sz = $urandom_range(11, 30);
          default: sz = $urandom_range(1, 8);
        endcase
        if (ph == 3 && s == 0) sz = 66;
        send_set(sz);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
